[design/pva_pkg.sv]
package pva_pkg;

	// Default voice count and fixed field widths
	localparam int NUM_VOICES_DEF = 16;
	localparam int NOTE_W         = 7;
	localparam int VEL_W          = 7;
	localparam int STAMP_W        = 32;
	localparam int SLOT_W         = 4;
	localparam int ENTRY_W        = NOTE_W + STAMP_W;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_IDLE     = 2'd2,
		OP_ALL_OFF  = 2'd3
	} op_t;

	// Result action codes
	typedef enum logic [1:0] {
		ACT_NONE        = 2'd0,
		ACT_START       = 2'd1,
		ACT_RELEASE     = 2'd2,
		ACT_RELEASE_ALL = 2'd3
	} act_t;

	// Outcome flags of one slot scan
	typedef struct packed {
		logic match_found;
		logic free_found;
	} scan_flags_t;

endpackage

[design/pva_ram.sv]
module pva_ram #(
	parameter int WIDTH = pva_pkg::ENTRY_W,
	parameter int DEPTH = pva_pkg::NUM_VOICES_DEF
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/pva_scan.sv]
module pva_scan #(
	parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
	parameter int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        sample,
	input  logic [IDX_W-1:0]            idx,
	input  logic [pva_pkg::NOTE_W-1:0]  entry_note,
	input  logic [pva_pkg::STAMP_W-1:0] entry_stamp,
	input  logic                        entry_valid,
	input  logic                        entry_active,
	input  logic [pva_pkg::NOTE_W-1:0]  note_key,
	output pva_pkg::scan_flags_t        flags,
	output logic [IDX_W-1:0]            match_idx,
	output logic [IDX_W-1:0]            free_idx,
	output logic [IDX_W-1:0]            best_idx
);

	logic                        match_found_q;
	logic                        free_found_q;
	logic [IDX_W-1:0]            match_idx_q;
	logic [IDX_W-1:0]            free_idx_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [pva_pkg::STAMP_W-1:0] best_stamp_q;
	logic                        hit_match;
	logic                        hit_free;
	logic                        take_best;

	// One note compare and one stamp compare per sampled slot
	assign hit_match = sample && !match_found_q && entry_valid && (entry_note == note_key);
	assign hit_free  = sample && !free_found_q && !entry_valid && !entry_active;
	assign take_best = sample && ((idx == '0) || (entry_stamp < best_stamp_q));

	// First-hit flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			if (hit_match) match_found_q <= 1'b1;
			if (hit_free)  free_found_q  <= 1'b1;
		end
	end

	// Winning indexes and running minimum stamp
	always_ff @(posedge clk) begin
		if (hit_match) match_idx_q <= idx;
		if (hit_free)  free_idx_q  <= idx;
		if (take_best) begin
			best_idx_q   <= idx;
			best_stamp_q <= entry_stamp;
		end
	end

	assign flags.match_found = match_found_q;
	assign flags.free_found  = free_found_q;
	assign match_idx         = match_idx_q;
	assign free_idx          = free_idx_q;
	assign best_idx          = best_idx_q;

endmodule

[design/polyphonic_voice_allocator.sv]
// Voice allocator: every input beat yields exactly one result beat. A note-on or
// note-off scans all NUM_VOICES slots through one read port of the slot memory and
// one shared note/stamp comparator. Its result is loaded after the last slot has been
// sampled and the sequencer has moved from ST_SCAN to ST_DONE, and in_ready returns
// with that load. Idle reports and all-notes-off go from ST_IDLE straight to ST_DONE
// and load their result from there, with no scan. A new beat is taken while the
// previous result still waits on the output register; a result that is still held
// there delays the next load until the receiver takes it.
// Note-on picks the slot already holding the note, else the lowest free slot, else
// steals the slot with the smallest start stamp (lowest index on ties). Slot indexes
// on the output are the low four bits of the internal slot number.
module polyphonic_voice_allocator #(
	parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [pva_pkg::NOTE_W-1:0] note,
	input  logic [pva_pkg::VEL_W-1:0]  velocity,
	input  logic [pva_pkg::SLOT_W-1:0] idle_slot,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 action,
	output logic [pva_pkg::SLOT_W-1:0] slot,
	output logic [pva_pkg::NOTE_W-1:0] out_note,
	output logic [pva_pkg::VEL_W-1:0]  out_velocity,
	output logic                       stolen,
	output logic                       retriggered
);

	localparam int IDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int RANGE_W = 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	pva_pkg::op_t                  op_q;
	logic [pva_pkg::NOTE_W-1:0]    note_q;
	logic [pva_pkg::VEL_W-1:0]     vel_q;
	logic [pva_pkg::SLOT_W-1:0]    idle_q;

	logic [NUM_VOICES-1:0]         valid_q;
	logic [NUM_VOICES-1:0]         key_q;
	logic [NUM_VOICES-1:0]         active_q;
	logic [pva_pkg::STAMP_W-1:0]   stamp_cnt_q;

	logic [IDX_W-1:0]              rd_addr_q;
	logic                          issue_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              rd_idx_s1;

	logic                          out_valid_q;
	pva_pkg::act_t                 action_q;
	logic [pva_pkg::SLOT_W-1:0]    slot_q;
	logic [pva_pkg::NOTE_W-1:0]    out_note_q;
	logic [pva_pkg::VEL_W-1:0]     out_vel_q;
	logic                          stolen_q;
	logic                          retrig_q;

	logic                          in_fire;
	logic                          out_load;
	logic                          scan_last;
	logic [pva_pkg::ENTRY_W-1:0]   rd_entry;
	pva_pkg::scan_flags_t          sflags;
	logic [IDX_W-1:0]              match_idx;
	logic [IDX_W-1:0]              free_idx;
	logic [IDX_W-1:0]              best_idx;
	logic [IDX_W-1:0]              sel_idx;
	logic                          steal;
	logic [IDX_W+pva_pkg::SLOT_W-1:0] sel_ext;
	logic [IDX_W+pva_pkg::SLOT_W-1:0] match_ext;
	logic [IDX_W-1:0]              idle_idx;
	logic                          idle_in_range;
	logic                          ram_we;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);

	// Slot choice once the scan is over
	assign steal     = !sflags.match_found && !sflags.free_found;
	assign sel_idx   = sflags.match_found ? match_idx :
	                   (sflags.free_found ? free_idx : best_idx);
	assign sel_ext   = {{pva_pkg::SLOT_W{1'b0}}, sel_idx};
	assign match_ext = {{pva_pkg::SLOT_W{1'b0}}, match_idx};

	assign idle_idx      = IDX_W'(idle_q);
	assign idle_in_range = {{(RANGE_W - pva_pkg::SLOT_W){1'b0}}, idle_q} < RANGE_W'(NUM_VOICES);

	assign ram_we = out_load && (op_q == pva_pkg::OP_NOTE_ON);

	// Note value and start stamp per slot
	pva_ram #(
		.WIDTH(pva_pkg::ENTRY_W),
		.DEPTH(NUM_VOICES)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sel_idx),
		.wdata({note_q, stamp_cnt_q}),
		.raddr(rd_addr_q),
		.rdata(rd_entry)
	);

	// Shared compare unit walking the slots
	pva_scan #(
		.NUM_VOICES(NUM_VOICES),
		.IDX_W     (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_fire),
		.sample      (rd_vld_s1),
		.idx         (rd_idx_s1),
		.entry_note  (rd_entry[pva_pkg::ENTRY_W-1:pva_pkg::STAMP_W]),
		.entry_stamp (rd_entry[pva_pkg::STAMP_W-1:0]),
		.entry_valid (valid_q[rd_idx_s1]),
		.entry_active(active_q[rd_idx_s1]),
		.note_key    (note_q),
		.flags       (sflags),
		.match_idx   (match_idx),
		.free_idx    (free_idx),
		.best_idx    (best_idx)
	);

	// Sequencer and read address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_addr_q <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && issue_q;
			rd_idx_s1 <= rd_addr_q;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rd_addr_q <= '0;
						if (op == pva_pkg::OP_NOTE_ON || op == pva_pkg::OP_NOTE_OFF) begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (rd_addr_q == LAST_IDX) issue_q <= 1'b0;
						else rd_addr_q <= rd_addr_q + 1'b1;
					end
					if (scan_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input beat capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= pva_pkg::op_t'(op);
			note_q <= note;
			vel_q  <= velocity;
			idle_q <= idle_slot;
		end
	end

	// Slot flags and stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			key_q       <= '0;
			active_q    <= '0;
			stamp_cnt_q <= '0;
		end else if (out_load) begin
			case (op_q)
				pva_pkg::OP_NOTE_ON: begin
					valid_q[sel_idx]  <= 1'b1;
					key_q[sel_idx]    <= 1'b1;
					active_q[sel_idx] <= 1'b1;
					stamp_cnt_q       <= stamp_cnt_q + 1'b1;
				end
				pva_pkg::OP_NOTE_OFF: begin
					if (sflags.match_found) key_q[match_idx] <= 1'b0;
				end
				pva_pkg::OP_IDLE: begin
					if (idle_in_range) begin
						active_q[idle_idx] <= 1'b0;
						if (!key_q[idle_idx]) valid_q[idle_idx] <= 1'b0;
					end
				end
				pva_pkg::OP_ALL_OFF: begin
					key_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			action_q   <= pva_pkg::ACT_NONE;
			slot_q     <= '0;
			out_note_q <= '0;
			out_vel_q  <= '0;
			stolen_q   <= 1'b0;
			retrig_q   <= 1'b0;
			case (op_q)
				pva_pkg::OP_NOTE_ON: begin
					action_q   <= pva_pkg::ACT_START;
					slot_q     <= sel_ext[pva_pkg::SLOT_W-1:0];
					out_note_q <= note_q;
					out_vel_q  <= vel_q;
					stolen_q   <= steal;
					retrig_q   <= sflags.match_found;
				end
				pva_pkg::OP_NOTE_OFF: begin
					if (sflags.match_found) begin
						action_q   <= pva_pkg::ACT_RELEASE;
						slot_q     <= match_ext[pva_pkg::SLOT_W-1:0];
						out_note_q <= note_q;
					end
				end
				pva_pkg::OP_ALL_OFF: begin
					action_q <= pva_pkg::ACT_RELEASE_ALL;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign slot         = slot_q;
	assign out_note     = out_note_q;
	assign out_velocity = out_vel_q;
	assign stolen       = stolen_q;
	assign retriggered  = retrig_q;

	// A started voice is never both a reuse and a steal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(stolen_q && retrig_q))
		else $error("stolen and retriggered both set");

	// Stealing only when every slot is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && op_q == pva_pkg::OP_NOTE_ON && steal) |-> (&(valid_q | active_q)))
		else $error("steal while a free slot exists");

	// Stamp counter moves only on a voice start
	assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_cnt_q != $past(stamp_cnt_q)) |-> $past(ram_we))
		else $error("stamp counter moved without a start");

	// Scan finishes with the read walk stopped
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_last) |-> !issue_q)
		else $error("scan ended while reads still pending");

endmodule

[verif/polyphonic_voice_allocator_tb.sv]
`timescale 1ns / 100ps

module polyphonic_voice_allocator_tb;

	localparam int VOICES      = pva_pkg::NUM_VOICES_DEF;
	localparam int NOTE_W      = pva_pkg::NOTE_W;
	localparam int VEL_W       = pva_pkg::VEL_W;
	localparam int SLOT_W      = pva_pkg::SLOT_W;
	localparam int STAMP_W     = pva_pkg::STAMP_W;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BEATS = 1400;
	localparam int DRAIN_CYCLES = 60;

	// One result beat as seen on the output ports
	typedef struct {
		pva_pkg::act_t    action;
		bit [SLOT_W-1:0]  slot;
		bit [NOTE_W-1:0]  note;
		bit [VEL_W-1:0]   vel;
		bit               stolen;
		bit               retrig;
	} voice_result_t;

	// One directed stimulus row; typed rows carry their own expected result
	typedef struct {
		pva_pkg::op_t     op;
		bit [NOTE_W-1:0]  note;
		bit [VEL_W-1:0]   vel;
		bit [SLOT_W-1:0]  idle;
		bit               typed;
		voice_result_t    res;
	} stim_row_t;

	localparam voice_result_t QUIET = '{pva_pkg::ACT_NONE, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          op;
	logic [NOTE_W-1:0]   note;
	logic [VEL_W-1:0]    velocity;
	logic [SLOT_W-1:0]   idle_slot;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          action;
	logic [SLOT_W-1:0]   slot;
	logic [NOTE_W-1:0]   out_note;
	logic [VEL_W-1:0]    out_velocity;
	logic                stolen;
	logic                retriggered;

	// Shadow copy of the slot table
	bit                  voice_held     [VOICES];
	bit [NOTE_W-1:0]     voice_note     [VOICES];
	bit                  voice_key_down [VOICES];
	bit                  voice_sounding [VOICES];
	bit [STAMP_W-1:0]    voice_stamp    [VOICES];
	bit [STAMP_W-1:0]    stamp_next;

	voice_result_t       pending_results[$];
	stim_row_t           dir_rows[$];
	int                  err_count;
	int                  cycle_count;

	polyphonic_voice_allocator #(.NUM_VOICES(VOICES)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.note         (note),
		.velocity     (velocity),
		.idle_slot    (idle_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.slot         (slot),
		.out_note     (out_note),
		.out_velocity (out_velocity),
		.stolen       (stolen),
		.retriggered  (retriggered)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Global watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
			cycle_count);
	endtask

	// Slot holding note n, or -1
	function automatic int find_held(input bit [NOTE_W-1:0] n);
		for (int i = 0; i < VOICES; i++)
			if (voice_held[i] && voice_note[i] == n)
				return i;
		return -1;
	endfunction

	// Allocation policy: same note, else lowest free slot, else oldest stamp
	task automatic predict_voice(input pva_pkg::op_t o, input bit [NOTE_W-1:0] n,
			input bit [VEL_W-1:0] v, input bit [SLOT_W-1:0] idx,
			output voice_result_t r);
		int s;
		int best;
		r = QUIET;
		case (o)
			pva_pkg::OP_NOTE_ON: begin
				s = find_held(n);
				if (s >= 0) begin
					r.retrig = 1'b1;
				end else begin
					for (int i = 0; i < VOICES; i++)
						if (s < 0 && !voice_sounding[i] && !voice_held[i])
							s = i;
					if (s < 0) begin
						best = 0;
						for (int i = 1; i < VOICES; i++)
							if (voice_stamp[i] < voice_stamp[best])
								best = i;
						s = best;
						r.stolen = 1'b1;
					end
				end
				voice_held[s]     = 1'b1;
				voice_note[s]     = n;
				voice_key_down[s] = 1'b1;
				voice_sounding[s] = 1'b1;
				voice_stamp[s]    = stamp_next;
				stamp_next        = stamp_next + 1;
				r.action = pva_pkg::ACT_START;
				r.slot   = s[SLOT_W-1:0];
				r.note   = n;
				r.vel    = v;
			end
			pva_pkg::OP_NOTE_OFF: begin
				s = find_held(n);
				if (s >= 0) begin
					voice_key_down[s] = 1'b0;
					r.action = pva_pkg::ACT_RELEASE;
					r.slot   = s[SLOT_W-1:0];
					r.note   = voice_note[s];
				end
			end
			pva_pkg::OP_IDLE: begin
				if (int'(idx) < VOICES) begin
					voice_sounding[idx] = 1'b0;
					if (!voice_key_down[idx])
						voice_held[idx] = 1'b0;
				end
			end
			default: begin
				for (int i = 0; i < VOICES; i++)
					voice_key_down[i] = 1'b0;
				r.action = pva_pkg::ACT_RELEASE_ALL;
			end
		endcase
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(8, 40);
	endfunction

	function automatic stim_row_t mk_row(input pva_pkg::op_t o, input int n, input int v,
			input int s, input bit typed, input voice_result_t r);
		stim_row_t row;
		row.op    = o;
		row.note  = n[NOTE_W-1:0];
		row.vel   = v[VEL_W-1:0];
		row.idle  = s[SLOT_W-1:0];
		row.typed = typed;
		row.res   = r;
		return row;
	endfunction

	// Random event biased toward held notes and sounding slots
	task automatic make_random_event(output pva_pkg::op_t o, output bit [NOTE_W-1:0] n,
			output bit [VEL_W-1:0] v, output bit [SLOT_W-1:0] s);
		int r;
		int pick;
		int held_q[$];
		int live_q[$];
		for (int i = 0; i < VOICES; i++) begin
			if (voice_held[i])
				held_q.push_back(i);
			if (voice_sounding[i])
				live_q.push_back(i);
		end
		n = NOTE_W'($urandom_range(0, 127));
		v = VEL_W'($urandom_range(0, 127));
		s = SLOT_W'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			o = pva_pkg::OP_NOTE_ON;
			pick = $urandom_range(0, 9);
			// narrow note pool keeps the table full, so steals happen
			if (pick < 6)
				n = NOTE_W'(40 + $urandom_range(0, 23));
			else if (pick < 8 && held_q.size() > 0)
				n = voice_note[held_q[$urandom_range(0, held_q.size() - 1)]];
		end else if (r < 72) begin
			o = pva_pkg::OP_NOTE_OFF;
			if ($urandom_range(0, 9) < 8 && held_q.size() > 0)
				n = voice_note[held_q[$urandom_range(0, held_q.size() - 1)]];
		end else if (r < 97) begin
			o = pva_pkg::OP_IDLE;
			if ($urandom_range(0, 9) < 7 && live_q.size() > 0)
				s = SLOT_W'(live_q[$urandom_range(0, live_q.size() - 1)]);
		end else begin
			o = pva_pkg::OP_ALL_OFF;
		end
	endtask

	// Offer one beat, hold it until taken, then log what it should produce
	task automatic send_event(input pva_pkg::op_t o, input bit [NOTE_W-1:0] n,
			input bit [VEL_W-1:0] v, input bit [SLOT_W-1:0] s, input bit typed,
			input voice_result_t typed_r, input int gap);
		voice_result_t pr;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		note      <= n;
		velocity  <= v;
		idle_slot <= s;
		do @(posedge clk); while (!in_ready);
		predict_voice(o, n, v, s, pr);
		pending_results.push_back(typed ? typed_r : pr);
	endtask

	// Result checker
	always @(posedge clk) begin : check_results
		voice_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", action, -1);
			end else begin
				want = pending_results.pop_front();
				if (action != want.action)
					report_mismatch("action", action, want.action);
				if (slot != want.slot)
					report_mismatch("slot", slot, want.slot);
				if (out_note != want.note)
					report_mismatch("out_note", out_note, want.note);
				if (out_velocity != want.vel)
					report_mismatch("out_velocity", out_velocity, want.vel);
				if (stolen != want.stolen)
					report_mismatch("stolen", stolen, want.stolen);
				if (retriggered != want.retrig)
					report_mismatch("retriggered", retriggered, want.retrig);
			end
		end
	end

	// Receiver: random stalls, ready-only stretches, one long hold-off
	initial begin : rx_side
		int stall;
		int cyc;
		int r;
		out_ready = 1'b0;
		stall = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			// long hold-off: output register and pipeline back up into in_ready
			if (cyc == 2500)
				stall = 600;
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ((cyc / 1500) % 4 == 3) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else if (r < 95) begin
					out_ready <= 1'b0;
					stall = $urandom_range(0, 3);
				end else begin
					out_ready <= 1'b0;
					stall = $urandom_range(10, 40);
				end
			end
		end
	end

	// Sender and run control
	initial begin : tx_side
		pva_pkg::op_t     ro;
		bit [NOTE_W-1:0]  rn;
		bit [VEL_W-1:0]   rv;
		bit [SLOT_W-1:0]  rs;
		err_count   = 0;
		cycle_count = 0;
		stamp_next  = '0;
		for (int i = 0; i < VOICES; i++) begin
			voice_held[i]     = 1'b0;
			voice_note[i]     = '0;
			voice_key_down[i] = 1'b0;
			voice_sounding[i] = 1'b0;
			voice_stamp[i]    = '0;
		end
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = pva_pkg::OP_NOTE_ON;
		note      = '0;
		velocity  = '0;
		idle_slot = '0;

		// Directed rows: empty table, extremes, retrigger, release, fill, steal
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_OFF, 5, 0, 0, 1'b1, QUIET));
		dir_rows.push_back(mk_row(pva_pkg::OP_IDLE, 0, 0, 0, 1'b1, QUIET));
		dir_rows.push_back(mk_row(pva_pkg::OP_ALL_OFF, 0, 0, 0, 1'b1,
			'{pva_pkg::ACT_RELEASE_ALL, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 0, 0, 15, 1'b1,
			'{pva_pkg::ACT_START, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 127, 127, 0, 1'b1,
			'{pva_pkg::ACT_START, 4'd1, 7'd127, 7'd127, 1'b0, 1'b0}));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 127, 64, 0, 1'b1,
			'{pva_pkg::ACT_START, 4'd1, 7'd127, 7'd64, 1'b0, 1'b1}));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_OFF, 127, 0, 0, 1'b1,
			'{pva_pkg::ACT_RELEASE, 4'd1, 7'd127, 7'd0, 1'b0, 1'b0}));
		for (int i = 0; i < VOICES - 2; i++)
			dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 10 + i, 9 * i, i, 1'b0, QUIET));
		// table is full: this one steals the oldest slot
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 100, 33, 0, 1'b0, QUIET));
		dir_rows.push_back(mk_row(pva_pkg::OP_ALL_OFF, 0, 0, 0, 1'b1,
			'{pva_pkg::ACT_RELEASE_ALL, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0}));
		// idle with key up drops the note, then the freed slot is reused
		dir_rows.push_back(mk_row(pva_pkg::OP_IDLE, 0, 0, 1, 1'b1, QUIET));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_OFF, 127, 0, 0, 1'b0, QUIET));
		dir_rows.push_back(mk_row(pva_pkg::OP_NOTE_ON, 127, 1, 0, 1'b0, QUIET));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_event(dir_rows[i].op, dir_rows[i].note, dir_rows[i].vel, dir_rows[i].idle,
				dir_rows[i].typed, dir_rows[i].res, pick_gap(1'b0));

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			make_random_event(ro, rn, rv, rs);
			send_event(ro, rn, rv, rs, 1'b0, QUIET, pick_gap((i / 100) % 4 == 1));
		end
		in_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
